### design/vlbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlbp_pkg: shared constants of the variable length bit packer
// Field widths of the request and response beats and the default word size.
// ----------------------------------------------------------------------------
package vlbp_pkg;

   localparam int VALUE_WIDTH   = 64;
   localparam int COUNT_WIDTH   = 7;
   localparam int OUT_WIDTH     = 32;
   localparam int WORD_WIDTH_DF = 32;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [OUT_WIDTH-1:0]   out_word_type;

endpackage
`default_nettype wire

### design/variable_length_bit_packer.sv
`default_nettype none
// The first word of a beat is offered on rsp the cycle after acceptance.
// One response word per cycle while rsp_ready is high; a beat that completes words
// holds the request side until its last word is taken, as the single response
// register drains the pending words.
// Reset (synchronous): accumulator and held count cleared, pending words dropped.
// ----------------------------------------------------------------------------
// variable_length_bit_packer: LSB-first packer into fixed-size words
// Appends the low bit_count bits (at most 64) of each beat and emits every completed word.
// ----------------------------------------------------------------------------
module variable_length_bit_packer #(
   parameter int WORD_WIDTH = vlbp_pkg::WORD_WIDTH_DF
) (
   input  wire  logic                   clock,
   input  wire  logic                   reset,
   input  wire  logic                   req_valid,
   output logic                         req_ready,
   input  wire  vlbp_pkg::value_type    req_value,
   input  wire  vlbp_pkg::count_type    req_bit_count,
   output logic                         rsp_valid,
   input  wire  logic                   rsp_ready,
   output vlbp_pkg::out_word_type       rsp_packed_word,
   output logic                         rsp_last_word
);
   import vlbp_pkg::*;

   localparam int HW   = $clog2(WORD_WIDTH);
   localparam int CW   = WORD_WIDTH + 63;
   localparam int MAXW = (WORD_WIDTH + 63) / WORD_WIDTH;
   localparam int KW   = $clog2(MAXW + 1);
   localparam int OW   = (WORD_WIDTH < OUT_WIDTH) ? WORD_WIDTH : OUT_WIDTH;

   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [HW-1:0]         held_ff, held_in;
   logic [CW-1:0]         pend_ff, pend_in;
   logic [KW-1:0]         left_ff, left_in;

   logic [CW-1:0]         merged;
   logic [KW-1:0]         words;
   logic [WORD_WIDTH-1:0] acc_next;
   logic [HW-1:0]         held_next;
   logic                  req_fire, rsp_fire;

   vlbp_merge #(.WORD_WIDTH(WORD_WIDTH)) u_merge (
      .acc       (acc_ff),
      .held      (held_ff),
      .value     (req_value),
      .bit_count (req_bit_count),
      .merged    (merged),
      .words     (words),
      .acc_next  (acc_next),
      .held_next (held_next)
   );

   assign rsp_valid       = (left_ff != '0);
   assign rsp_last_word   = (left_ff == KW'(1));
   assign rsp_packed_word = OUT_WIDTH'(pend_ff[OW-1:0]);
   assign req_ready       = (left_ff == '0) || (rsp_last_word && rsp_ready);
   assign req_fire        = req_valid && req_ready;
   assign rsp_fire        = rsp_valid && rsp_ready;

   always_comb begin
      acc_in  = acc_ff;
      held_in = held_ff;
      pend_in = pend_ff;
      left_in = left_ff;
      if (req_fire) begin
         acc_in  = acc_next;
         held_in = held_next;
         pend_in = merged;
         left_in = words;
      end else if (rsp_fire) begin
         pend_in = pend_ff >> WORD_WIDTH;
         left_in = left_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
         left_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
         left_ff <= left_in;
      end
   end

`ifndef ASSERT_OFF
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff >> held_ff) == '0)
      else $error("accumulator holds bits above the held count");

   a_full_beat_emits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bit_count >= COUNT_WIDTH'(VALUE_WIDTH)) |=> rsp_valid)
      else $error("full-width beat completed no word");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_word && !req_fire) |=> !rsp_valid)
      else $error("response still valid after last word taken");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with no pending words");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      left_ff <= KW'(MAXW))
      else $error("pending word count exceeds maximum");
`endif

endmodule
`default_nettype wire

### design/vlbp_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlbp_merge: append one beat to the accumulator
// Masks the value to its clamped count, places it above the held bits, and
// splits the result into completed words and the leftover partial word.
// ----------------------------------------------------------------------------
module vlbp_merge #(
   parameter int WORD_WIDTH = vlbp_pkg::WORD_WIDTH_DF
) (
   input  wire  logic [WORD_WIDTH-1:0]             acc,
   input  wire  logic [$clog2(WORD_WIDTH)-1:0]     held,
   input  wire  vlbp_pkg::value_type               value,
   input  wire  vlbp_pkg::count_type               bit_count,
   output logic [WORD_WIDTH+62:0]                  merged,
   output logic [$clog2((WORD_WIDTH+63)/WORD_WIDTH+1)-1:0] words,
   output logic [WORD_WIDTH-1:0]                   acc_next,
   output logic [$clog2(WORD_WIDTH)-1:0]           held_next
);
   import vlbp_pkg::*;

   localparam int HW   = $clog2(WORD_WIDTH);
   localparam int CW   = WORD_WIDTH + 63;
   localparam int TW   = $clog2(WORD_WIDTH + 64);
   localparam int MAXW = (WORD_WIDTH + 63) / WORD_WIDTH;
   localparam int KW   = $clog2(MAXW + 1);

   count_type     n;
   value_type     vm;
   logic [TW-1:0] total;
   logic [TW-1:0] used;

   always_comb begin
      n      = (bit_count > COUNT_WIDTH'(VALUE_WIDTH)) ? COUNT_WIDTH'(VALUE_WIDTH) : bit_count;
      vm     = value & ~({VALUE_WIDTH{1'b1}} << n);
      merged = CW'(acc) | (CW'(vm) << held);
      total  = TW'(held) + TW'(n);
      words  = '0;
      used   = '0;
      for (int j = 1; j <= MAXW; j++) begin
         if (total >= TW'(j * WORD_WIDTH)) begin
            words = KW'(j);
            used  = TW'(j * WORD_WIDTH);
         end
      end
      held_next = HW'(total - used);
      acc_next  = WORD_WIDTH'(merged >> used);
   end

endmodule
`default_nettype wire
